/* hw/rtl/rigf_pkg.sv */
// Shared types and constants for the region invert / grayscale filter.
package rigf_pkg;

   // Field widths
   localparam int unsigned COORD_W  = 12;
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned DIM_W    = 13;
   localparam int unsigned CORNER_W = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // BT.709 luma weights, 16-bit fractions (sum is 65536)
   localparam int unsigned LUMA_FRAC_W = 16;
   localparam int unsigned PROD_W      = LUMA_FRAC_W + CHAN_W;
   localparam logic [LUMA_FRAC_W-1:0] LUMA_WR = 16'd13933;
   localparam logic [LUMA_FRAC_W-1:0] LUMA_WG = 16'd46871;
   localparam logic [LUMA_FRAC_W-1:0] LUMA_WB = 16'd4732;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_CORNER_A_X   = 3'd2,
      CSR_CORNER_A_Y   = 3'd3,
      CSR_CORNER_B_X   = 3'd4,
      CSR_CORNER_B_Y   = 3'd5,
      CSR_FILTER_MODE  = 3'd6
   } csr_index_type;

   typedef enum logic {
      MODE_INVERT = 1'b0,
      MODE_GRAY   = 1'b1
   } filter_mode_type;

   // Clipped rectangle, half-open on the max side
   typedef struct packed {
      logic [DIM_W-1:0] x_min;
      logic [DIM_W-1:0] x_max;
      logic [DIM_W-1:0] y_min;
      logic [DIM_W-1:0] y_max;
   } rect_type;

   // Raw configuration as held in the register bank
   typedef struct packed {
      logic [DIM_W-1:0]    image_width;
      logic [DIM_W-1:0]    image_height;
      logic [CORNER_W-1:0] corner_a_x;
      logic [CORNER_W-1:0] corner_a_y;
      logic [CORNER_W-1:0] corner_b_x;
      logic [CORNER_W-1:0] corner_b_y;
      filter_mode_type     filter_mode;
   } cfg_type;

endpackage

/* hw/rtl/rigf_if.sv */
// Pixel request and response channel interfaces.
interface rigf_req_if
   import rigf_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   logic [CHAN_W-1:0]  in_red;
   logic [CHAN_W-1:0]  in_green;
   logic [CHAN_W-1:0]  in_blue;

   modport source (output valid, pixel_x, pixel_y, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, pixel_x, pixel_y, in_red, in_green, in_blue, output ready);
endinterface

interface rigf_rsp_if
   import rigf_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_red;
   logic [CHAN_W-1:0] out_green;
   logic [CHAN_W-1:0] out_blue;
   logic              in_region;

   modport source (output valid, out_red, out_green, out_blue, in_region, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, in_region, output ready);
endinterface

/* hw/rtl/rigf_bounds.sv */
// Rectangle clamp, ordering and clipping against the image size.
module rigf_bounds
   import rigf_pkg::*;
#(
   parameter int unsigned MAX_DIM = 4096
) (
   input  cfg_type  cfg,
   output rect_type rect
);

   localparam int unsigned      LIM_W   = DIM_W + 4;
   localparam logic [LIM_W-1:0] MaxDimV = LIM_W'(MAX_DIM);

   logic [DIM_W-1:0]    w_lim;
   logic [DIM_W-1:0]    h_lim;
   logic [CORNER_W-1:0] ax, ay, bx, by;
   logic [CORNER_W-1:0] x_lo, x_hi, y_lo, y_hi;

   // Clamp a signed corner: negative reads as zero
   function automatic logic [CORNER_W-1:0] clamp_corner(input logic [CORNER_W-1:0] raw);
      return raw[CORNER_W-1] ? '0 : raw;
   endfunction

   // Clip a corner value to the image dimension
   function automatic logic [DIM_W-1:0] clip(input logic [CORNER_W-1:0] v,
                                             input logic [DIM_W-1:0]    lim);
      logic [CORNER_W-1:0] lim_ext;
      lim_ext = CORNER_W'(lim);
      return (v < lim_ext) ? v[DIM_W-1:0] : lim;
   endfunction

   // Image size limited to the largest supported dimension
   always_comb begin
      w_lim = (LIM_W'(cfg.image_width) > MaxDimV) ? DIM_W'(MAX_DIM) : cfg.image_width;
      h_lim = (LIM_W'(cfg.image_height) > MaxDimV) ? DIM_W'(MAX_DIM) : cfg.image_height;
   end

   // Clamp and order the corners
   always_comb begin
      ax   = clamp_corner(cfg.corner_a_x);
      ay   = clamp_corner(cfg.corner_a_y);
      bx   = clamp_corner(cfg.corner_b_x);
      by   = clamp_corner(cfg.corner_b_y);
      x_lo = (ax < bx) ? ax : bx;
      x_hi = (ax < bx) ? bx : ax;
      y_lo = (ay < by) ? ay : by;
      y_hi = (ay < by) ? by : ay;
   end

   // Clip to the image
   always_comb begin
      rect.x_min = clip(x_lo, w_lim);
      rect.x_max = clip(x_hi, w_lim);
      rect.y_min = clip(y_lo, h_lim);
      rect.y_max = clip(y_hi, h_lim);
   end

endmodule

/* hw/rtl/region_invert_grayscale_filter.sv */
// Top level of the region invert / grayscale pixel filter.
//
//   channel   direction  handshake          payload
//   req_ch    in         valid / ready      pixel_x, pixel_y, in_red, in_green, in_blue
//   rsp_ch    out        valid / ready      out_red, out_green, out_blue, in_region
//   csr_*     in         csr_we (no ready)  csr_index, csr_wdata
//
// One pixel per clock sustained while rsp_ch is ready.
// Stage 1 registers the clipped rectangle, stage 2 the region test and luma
// products, stage 3 the luma sum and output select (the output register).
// Synchronous active-high reset clears the configuration registers and all valid bits.
// A stall on rsp_ch holds each full stage; empty stages still fill.
module region_invert_grayscale_filter
   import rigf_pkg::*;
#(
   parameter int unsigned MAX_DIM = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   rigf_req_if.sink              req_ch,
   rigf_rsp_if.source            rsp_ch
);

   // Configuration registers
   cfg_type  cfg_ff;
   rect_type rect;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{default: '0, filter_mode: MODE_INVERT};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata[DIM_W-1:0];
            CSR_CORNER_A_X:   cfg_ff.corner_a_x   <= csr_wdata;
            CSR_CORNER_A_Y:   cfg_ff.corner_a_y   <= csr_wdata;
            CSR_CORNER_B_X:   cfg_ff.corner_b_x   <= csr_wdata;
            CSR_CORNER_B_Y:   cfg_ff.corner_b_y   <= csr_wdata;
            CSR_FILTER_MODE:  cfg_ff.filter_mode  <= filter_mode_type'(csr_wdata[0]);
            default: ;
         endcase
      end
   end

   rigf_bounds #(.MAX_DIM(MAX_DIM)) u_bounds (
      .cfg  (cfg_ff),
      .rect (rect)
   );

   // Stage enables: a stage moves when it is empty or the next one moves
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic en1, en2, en3;

   always_comb begin
      en3 = !s3_valid_ff || rsp_ch.ready;
      en2 = !s2_valid_ff || en3;
      en1 = !s1_valid_ff || en2;
   end

   assign req_ch.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_ch.valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 1: capture the pixel and the clipped rectangle
   logic [COORD_W-1:0] s1_x_ff, s1_y_ff;
   logic [CHAN_W-1:0]  s1_r_ff, s1_g_ff, s1_b_ff;
   rect_type           s1_rect_ff;
   filter_mode_type    s1_mode_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_x_ff    <= req_ch.pixel_x;
         s1_y_ff    <= req_ch.pixel_y;
         s1_r_ff    <= req_ch.in_red;
         s1_g_ff    <= req_ch.in_green;
         s1_b_ff    <= req_ch.in_blue;
         s1_rect_ff <= rect;
         s1_mode_ff <= cfg_ff.filter_mode;
      end
   end

   // Stage 2: region test and weighted channels
   logic               s2_inside_in;
   logic [PROD_W-1:0]  s2_pr_in, s2_pg_in, s2_pb_in;
   logic               s2_inside_ff;
   logic [PROD_W-1:0]  s2_pr_ff, s2_pg_ff, s2_pb_ff;
   logic [CHAN_W-1:0]  s2_r_ff, s2_g_ff, s2_b_ff;
   filter_mode_type    s2_mode_ff;

   always_comb begin
      s2_inside_in = (DIM_W'(s1_x_ff) >= s1_rect_ff.x_min) &&
                     (DIM_W'(s1_x_ff) <  s1_rect_ff.x_max) &&
                     (DIM_W'(s1_y_ff) >= s1_rect_ff.y_min) &&
                     (DIM_W'(s1_y_ff) <  s1_rect_ff.y_max);
      s2_pr_in = PROD_W'(LUMA_WR) * PROD_W'(s1_r_ff);
      s2_pg_in = PROD_W'(LUMA_WG) * PROD_W'(s1_g_ff);
      s2_pb_in = PROD_W'(LUMA_WB) * PROD_W'(s1_b_ff);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_inside_ff <= s2_inside_in;
         s2_pr_ff     <= s2_pr_in;
         s2_pg_ff     <= s2_pg_in;
         s2_pb_ff     <= s2_pb_in;
         s2_r_ff      <= s1_r_ff;
         s2_g_ff      <= s1_g_ff;
         s2_b_ff      <= s1_b_ff;
         s2_mode_ff   <= s1_mode_ff;
      end
   end

   // Stage 3: luma sum and output select; weights sum to one so no overflow
   logic [PROD_W-1:0] luma_sum;
   logic [CHAN_W-1:0] luma;
   logic [CHAN_W-1:0] s3_r_in, s3_g_in, s3_b_in;
   logic [CHAN_W-1:0] s3_r_ff, s3_g_ff, s3_b_ff;
   logic              s3_inside_ff;

   always_comb begin
      luma_sum = s2_pr_ff + s2_pg_ff + s2_pb_ff;
      luma     = luma_sum[PROD_W-1:LUMA_FRAC_W];
      s3_r_in  = s2_r_ff;
      s3_g_in  = s2_g_ff;
      s3_b_in  = s2_b_ff;
      if (s2_inside_ff) begin
         if (s2_mode_ff == MODE_GRAY) begin
            s3_r_in = luma;
            s3_g_in = luma;
            s3_b_in = luma;
         end else begin
            s3_r_in = ~s2_r_ff;
            s3_g_in = ~s2_g_ff;
            s3_b_in = ~s2_b_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_r_ff      <= s3_r_in;
         s3_g_ff      <= s3_g_in;
         s3_b_ff      <= s3_b_in;
         s3_inside_ff <= s2_inside_ff;
      end
   end

   assign rsp_ch.valid     = s3_valid_ff;
   assign rsp_ch.out_red   = s3_r_ff;
   assign rsp_ch.out_green = s3_g_ff;
   assign rsp_ch.out_blue  = s3_b_ff;
   assign rsp_ch.in_region = s3_inside_ff;

endmodule
